@@ rtl/core/hrfp_pkg.sv @@
// Package for the reply frame parser: lead and terminator codes, frame
// sizes, result kinds and the frame event struct. No dependencies.
package hrfp_pkg;

  localparam logic [7:0] LEAD_STRING = 8'h70;
  localparam logic [7:0] LEAD_NUMBER = 8'h71;
  localparam logic [7:0] TERM_BYTE   = 8'hFF;

  localparam int unsigned NUMBER_FRAME_LEN = 8;
  localparam int unsigned OVERHEAD_LEN     = 4;
  localparam int unsigned TERM_LEN         = 3;
  localparam int unsigned NUMBER_BYTES     = 4;

  typedef enum logic [1:0] {
    KIND_STR   = 2'd0,
    KIND_NUM   = 2'd1,
    KIND_EMPTY = 2'd2
  } hrfp_kind_t;

  // Frame status seen on the cycle a byte is stored.
  typedef struct packed {
    logic term;      // this byte completes a triple 0xFF terminator
    logic is_str;    // lead byte is a string lead
    logic is_num;    // numeric lead and numeric frame length
    logic str_empty; // frame length equals the overhead: no payload bytes
  } hrfp_evt_t;

endpackage

@@ rtl/core/hrfp_if.sv @@
// Valid/ready channel interfaces for received bytes and parsed results.
// Depends on hrfp_pkg.
interface hrfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hrfp_res_if;
  import hrfp_pkg::*;
  logic               valid;
  logic               ready;
  hrfp_kind_t         kind;
  logic [7:0]         data_byte;
  logic signed [31:0] number_value;
  logic               last;

  modport source (output valid, output kind, output data_byte, output number_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input number_value,
                  input last, output ready);
endinterface

@@ rtl/core/hrfp_capture.sv @@
// Frame store with fill count, terminator run tracking and a registered
// read port. Depends on hrfp_pkg.
module hrfp_capture #(
  parameter int FRAME_DEPTH = 64,
  parameter int CNT_W       = 7,
  parameter int ADDR_W      = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [7:0]          wr_data,
  output hrfp_pkg::hrfp_evt_t evt,
  output logic [CNT_W-1:0]    len,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [7:0]          rd_data
);
  import hrfp_pkg::*;

  logic [7:0]       mem [FRAME_DEPTH];
  logic [7:0]       rd_data_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [1:0]       run_r, run_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [7:0]       lead_eff;
  logic             is_ff;
  logic             full;

  assign is_ff    = (wr_data == TERM_BYTE);
  assign len      = fill_r + CNT_W'(1);
  assign lead_eff = (fill_r == '0) ? wr_data : lead_r;
  assign full     = (len == CNT_W'(FRAME_DEPTH));

  always_comb begin
    evt.term      = is_ff && (run_r >= 2'(TERM_LEN - 1));
    evt.is_str    = (lead_eff == LEAD_STRING);
    evt.is_num    = (lead_eff == LEAD_NUMBER) && (len == CNT_W'(NUMBER_FRAME_LEN));
    evt.str_empty = (len == CNT_W'(OVERHEAD_LEN));
  end

  always_comb begin
    fill_nxt = fill_r;
    run_nxt  = run_r;
    lead_nxt = lead_r;
    if (wr_en) begin
      lead_nxt = lead_eff;
      if (evt.term || full) begin
        // restart the frame
        fill_nxt = '0;
        run_nxt  = '0;
      end else begin
        fill_nxt = len;
        run_nxt  = is_ff ? ((run_r == 2'd3) ? run_r : run_r + 2'd1) : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      run_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      run_r  <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r <= lead_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CNT_W'(FRAME_DEPTH))
    else $error("fill count beyond frame depth");

  a_term_restart: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && evt.term |=> fill_r == '0 && run_r == '0)
    else $error("frame not restarted after terminator");

  a_run_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    run_r != '0 |-> fill_r != '0)
    else $error("terminator run outside a frame");

endmodule

@@ rtl/core/hmi_reply_frame_parser_top.sv @@
// Reply frame parser top level: byte capture, result sequencer and output
// register. Depends on hrfp_pkg, hrfp_if and hrfp_capture.
//
// Each received byte is stored as it is accepted; the input stays ready
// unless the byte completed a string frame or a numeric frame of the right
// length (a dropped frame leaves the input ready). A string frame then yields
// one result per character, each passing through memory read, load and
// hand-off, the hand-off held while the sink holds ready low; the input stays
// stalled until the last character is handed off. A numeric frame reads its
// four value bytes, each with a read and a load, and hands off one result; an
// empty string frame hands off one result at once. The pace is set by the
// single read port of the frame store, read one entry at a time. No clearing
// pass is needed after reset.
module hmi_reply_frame_parser_top #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  hrfp_rx_if.sink     in_ch,
  hrfp_res_if.source  out_ch
);
  import hrfp_pkg::*;

  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int ADDR_W = $clog2(FRAME_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_LD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic               num_mode_r, num_mode_nxt;
  logic               out_valid_r, out_valid_nxt;
  hrfp_kind_t         kind_r, kind_nxt;
  logic [7:0]         data_r, data_nxt;
  logic signed [31:0] num_r, num_nxt;
  logic               last_r, last_nxt;

  logic               in_acc;
  hrfp_evt_t          evt;
  logic [CNT_W-1:0]   len;
  logic               rd_en;
  logic [7:0]         rd_data;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  hrfp_capture #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (in_ch.rx_byte),
    .evt     (evt),
    .len     (len),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign rd_en = (state_r == S_RD);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    num_mode_nxt  = num_mode_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    data_nxt      = data_r;
    num_nxt       = num_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && evt.term) begin
          idx_nxt = ADDR_W'(1);
          if (evt.is_str && evt.str_empty) begin
            kind_nxt      = KIND_EMPTY;
            data_nxt      = '0;
            num_nxt       = '0;
            last_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else if (evt.is_str) begin
            // characters sit between the lead byte and the terminator
            end_nxt      = ADDR_W'(len - CNT_W'(OVERHEAD_LEN));
            num_mode_nxt = 1'b0;
            state_nxt    = S_RD;
          end else if (evt.is_num) begin
            end_nxt      = ADDR_W'(NUMBER_BYTES);
            num_mode_nxt = 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        if (num_mode_r) begin
          // little-endian: shift each byte in from the top
          num_nxt = {rd_data, num_r[31:8]};
          if (idx_r == end_r) begin
            kind_nxt      = KIND_NUM;
            data_nxt      = '0;
            last_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          kind_nxt      = KIND_STR;
          data_nxt      = rd_data;
          num_nxt       = '0;
          last_nxt      = (idx_r == end_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    num_mode_r <= num_mode_nxt;
    kind_r     <= kind_nxt;
    data_r     <= data_nxt;
    num_r      <= num_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.data_byte    = data_r;
  assign out_ch.number_value = num_r;
  assign out_ch.last         = last_r;

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_OUT))
    else $error("result valid outside hand-off state");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_valid_r)
    else $error("input ready while a result is pending");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_STR |-> last_r)
    else $error("single-result frame without last");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> idx_r <= end_r && idx_r != '0)
    else $error("read index outside frame payload");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the reply frame parser: drives received bytes, predicts the
// parsed results and checks them on the result channel.
// Depends on hrfp_pkg, hrfp_if and hmi_reply_frame_parser_top.
`timescale 1ns / 1ps

module tb_top;
  import hrfp_pkg::*;

  localparam int FRAME_DEPTH  = 64;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_BYTES = 20;

  typedef struct packed {
    hrfp_kind_t         kind;
    logic [7:0]         data_byte;
    logic signed [31:0] number_value;
    logic               last;
  } parse_result_t;

  logic clk;
  logic rst_n;

  hrfp_rx_if  rx_ch();
  hrfp_res_if res_ch();

  hmi_reply_frame_parser_top #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (rx_ch),
    .out_ch(res_ch)
  );

  // Frame parser state as seen from outside.
  logic [7:0]    frame_buf [FRAME_DEPTH];
  int unsigned   fill_cnt;
  parse_result_t pending_results [$];

  bit idle_en;
  int error_cnt;
  int mismatch_cnt;
  int bytes_sent;
  int frames_closed;
  int results_seen;
  int str_seen;
  int num_seen;
  int empty_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL hmi_reply_frame_parser_top");
    $finish;
  end

  function void push_result(hrfp_kind_t k, logic [7:0] d, logic signed [31:0] v, logic l);
    parse_result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.number_value = v;
    r.last         = l;
    pending_results.push_back(r);
  endfunction

  // Store one byte and queue whatever results a completed frame yields.
  function void parse_rx_byte(logic [7:0] b);
    int unsigned n;
    if (fill_cnt >= FRAME_DEPTH) fill_cnt = 0;
    frame_buf[fill_cnt] = b;
    fill_cnt++;
    n = fill_cnt;
    if (n >= TERM_LEN && frame_buf[n-1] == TERM_BYTE && frame_buf[n-2] == TERM_BYTE &&
        frame_buf[n-3] == TERM_BYTE) begin
      if (frame_buf[0] == LEAD_STRING) begin
        if (n == OVERHEAD_LEN) begin
          push_result(KIND_EMPTY, 8'h00, 32'sd0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n - OVERHEAD_LEN; i++)
            push_result(KIND_STR, frame_buf[1+i], 32'sd0, (i + 1 == n - OVERHEAD_LEN));
        end
      end else if (frame_buf[0] == LEAD_NUMBER && n == NUMBER_FRAME_LEN) begin
        push_result(KIND_NUM, 8'h00,
                    {frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]}, 1'b1);
      end
      fill_cnt = 0;
      frames_closed++;
    end else if (fill_cnt >= FRAME_DEPTH) begin
      fill_cnt = 0;
    end
  endfunction

  // Valid stays high across back-to-back requests; lower it only for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_term();
    repeat (TERM_LEN) send_byte(TERM_BYTE);
  endtask

  task automatic send_number_frame(input logic [31:0] v);
    send_byte(LEAD_NUMBER);
    for (int i = 0; i < NUMBER_BYTES; i++) send_byte(v[8*i +: 8]);
    send_term();
  endtask

  function logic [7:0] rand_char();
    // Bias toward 0xFF so runs of terminator bytes show up inside payloads.
    return ($urandom_range(0, 5) == 0) ? TERM_BYTE : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame();
    int sel;
    int len;
    logic [7:0] lead;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      len = $urandom_range(0, 12);
      send_byte(LEAD_STRING);
      repeat (len) send_byte(rand_char());
      send_term();
    end else if (sel < 60) begin
      case ($urandom_range(0, 5))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h0000_0000;
        3:       v = 32'hFFFF_FFFE;
        default: v = $urandom;
      endcase
      send_number_frame(v);
    end else if (sel < 70) begin
      // Numeric lead with a wrong value length.
      len = $urandom_range(0, 5);
      if (len >= NUMBER_BYTES) len++;
      send_byte(LEAD_NUMBER);
      repeat (len) send_byte(8'($urandom_range(0, 254)));
      send_term();
    end else if (sel < 80) begin
      do lead = 8'($urandom_range(0, 255));
      while (lead == LEAD_STRING || lead == LEAD_NUMBER);
      send_byte(lead);
      repeat ($urandom_range(0, 6)) send_byte(rand_char());
      send_term();
    end else if (sel < 90) begin
      // Stray bytes with no terminator; they merge into the next frame.
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(LEAD_STRING);
      send_byte(8'($urandom_range(0, 254)));
      send_byte(TERM_BYTE);
      send_byte(TERM_BYTE);
      send_byte(8'($urandom_range(0, 254)));
      send_term();
    end
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    // Empty string frame.
    send_byte(LEAD_STRING);
    send_term();
    // Most negative number.
    send_number_frame(32'h8000_0000);
    // String holding a zero byte and a lone terminator byte.
    send_byte(LEAD_STRING);
    send_byte(8'h00);
    send_byte(TERM_BYTE);
    send_byte(8'h41);
    send_term();
    // Numeric lead, too short: dropped.
    send_byte(LEAD_NUMBER);
    send_byte(8'h01);
    send_term();
  endtask

  task automatic test_long_frames();
    idle_en = 1'b1;
    // Longest string the store can hold.
    send_byte(LEAD_STRING);
    repeat (FRAME_DEPTH - OVERHEAD_LEN) send_byte(8'($urandom_range(0, 254)));
    send_term();
    // Fill the store without a terminator: dropped, then realign.
    send_byte(LEAD_STRING);
    repeat (FRAME_DEPTH - 1) send_byte(8'($urandom_range(0, 254)));
    send_number_frame(32'h7FFF_FFFF);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (3) send_random_frame();
  endtask

  task automatic test_random_frames();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      idle_en = ($urandom_range(0, 3) != 0);
      send_random_frame();
    end
    idle_en = 1'b1;
  endtask

  // Result sink: random stalls between requests.
  initial begin
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = idle_en ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      case (res_ch.kind)
        KIND_STR:   str_seen++;
        KIND_NUM:   num_seen++;
        KIND_EMPTY: empty_seen++;
        default:    ;
      endcase
      if (pending_results.size() == 0) begin
        error_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d data=%h num=%0d last=%b", $realtime,
                   res_ch.kind, res_ch.data_byte, res_ch.number_value, res_ch.last);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.data_byte !== want.data_byte ||
            res_ch.number_value !== want.number_value || res_ch.last !== want.last) begin
          error_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: mismatch exp kind=%0d data=%h num=%0d last=%b",
                     $realtime, want.kind, want.data_byte, want.number_value, want.last);
            $display("    got kind=%0d data=%h num=%0d last=%b",
                     res_ch.kind, res_ch.data_byte, res_ch.number_value, res_ch.last);
          end
        end
      end
    end
  end

  initial begin
    fill_cnt      = 0;
    idle_en       = 1'b1;
    error_cnt     = 0;
    mismatch_cnt  = 0;
    bytes_sent    = 0;
    frames_closed = 0;
    results_seen  = 0;
    str_seen      = 0;
    num_seen      = 0;
    empty_seen    = 0;
    rst_n         <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_long_frames();
    test_back_to_back();
    test_random_frames();

    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      error_cnt++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (mismatch_cnt > MAX_REPORTS)
      $display("%0d further mismatches not shown", mismatch_cnt - MAX_REPORTS);
    $display("Sent %0d bytes closing %0d frames; checked %0d results", bytes_sent,
             frames_closed, results_seen);
    $display("  (%0d string bytes, %0d numbers, %0d empty strings)", str_seen, num_seen,
             empty_seen);
    if (error_cnt == 0) begin
      $display("PASS hmi_reply_frame_parser_top");
    end else begin
      $display("FAIL hmi_reply_frame_parser_top");
    end
    $finish;
  end

endmodule
